// ===== src/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg - shared types, constants and helpers for the frame decoder
// CRC-8 step over one byte and the exact divide by full scale.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    // CRC-8: polynomial 0x31, seed 0xFF, MSB first, no reflection, no final xor
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;

    // Scaling constants
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUMID_SPAN  = 14'd10000;

    // Quotient and remainder of a product divided by full scale
    typedef struct packed {
        logic [14:0] quot;
        logic [15:0] rem;
    } fs_div_t;

    // Advance the CRC over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC over the high byte, then the low byte of a word
    function automatic logic [7:0] crc8_word(input logic [15:0] word);
        return crc8_byte(crc8_byte(CRC_INIT, word[15:8]), word[7:0]);
    endfunction

    // Floor divide by 2^16-1 for num < 2^31: 2^16 = 65535 + 1, so
    // num = hi*65535 + (hi + lo); the partial remainder stays below
    // twice the divisor, so one compare and subtract corrects it.
    function automatic fs_div_t div_full_scale(input logic [30:0] num);
        logic [14:0] q0;
        logic [16:0] r0;
        fs_div_t     res;
        q0 = num[30:16];
        r0 = {1'b0, num[15:0]} + {2'b00, q0};
        if (r0 >= {1'b0, FULL_SCALE})
        begin
            res.quot = q0 + 15'd1;
            res.rem  = 16'(r0 - {1'b0, FULL_SCALE});
        end
        else
        begin
            res.quot = q0;
            res.rem  = r0[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/humidity_temp_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder - sensor frame CRC check and scaling
// Checks both CRC-8 bytes of a temperature/humidity frame (polynomial 0x31,
// seed 0xFF, high byte first) and scales the raw words to hundredths:
// temperature = raw*17500/65535 - 4500 (truncated toward zero), humidity =
// raw*10000/65535 (truncated). A failed check on either word gives status 1
// and zero for both values. The block takes one frame per clock while results
// are taken and returns one result per frame, which passes through the frame
// register and then the result register. Each register advances only
// when the stage behind it is empty or handing off, so a stalled result
// holds without losing frames, and throughput stays at one frame per cycle
// as long as results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_decoder
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // Frame channel
    input  wire logic               frame_valid,
    output logic                    frame_ready,
    input  wire logic [15:0]        temp_word,
    input  wire logic [7:0]         temp_check,
    input  wire logic [15:0]        raw_humid,
    input  wire logic [7:0]         humid_check,

    // Result channel
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic                    frame_status,
    output logic signed [14:0]      temp_centi,
    output logic [13:0]             humid_centi
);

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    logic        result_load;
    logic        stage_load;

    // Load the result register when it is empty or its transfer completes
    assign result_load  = !result_valid_reg || result_ready;
    // Load the frame register when it is empty or drains into the result
    assign frame_ready  = !stage_valid_reg || result_load;
    assign stage_load   = frame_valid && frame_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (frame_ready)
        begin
            stage_valid_next = frame_valid;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_load)
        begin
            result_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame register: hold the payload of the accepted transfer
    // ------------------------------------------------------------------
    logic [15:0] temp_word_reg;
    logic [7:0]  temp_check_reg;
    logic [15:0] raw_humid_reg;
    logic [7:0]  humid_check_reg;

    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            temp_word_reg   <= temp_word;
            temp_check_reg  <= temp_check;
            raw_humid_reg   <= raw_humid;
            humid_check_reg <= humid_check;
        end
    end

    // ------------------------------------------------------------------
    // CRC check: both words must match their received bytes
    // ------------------------------------------------------------------
    logic crc_ok;

    assign crc_ok = (htfd_pkg::crc8_word(temp_word_reg) == temp_check_reg) &&
                    (htfd_pkg::crc8_word(raw_humid_reg) == humid_check_reg);

    // ------------------------------------------------------------------
    // Scaling: one constant multiply per word, then the exact divide
    // ------------------------------------------------------------------
    logic [30:0]           temp_prod;
    logic [30:0]           humid_prod;
    htfd_pkg::fs_div_t     temp_div;
    htfd_pkg::fs_div_t     humid_div;
    logic [15:0]           temp_floor;
    logic                  temp_round_up;
    logic [15:0]           temp_trunc;

    assign temp_prod  = {15'd0, temp_word_reg} * {16'd0, htfd_pkg::TEMP_SPAN};
    assign humid_prod = {15'd0, raw_humid_reg} * {17'd0, htfd_pkg::HUMID_SPAN};

    assign temp_div   = htfd_pkg::div_full_scale(temp_prod);
    assign humid_div  = htfd_pkg::div_full_scale(humid_prod);

    // The offset is a whole multiple of full scale, so floor(q) - offset is
    // the floor of the full expression; bump negative inexact values up to
    // truncate toward zero.
    assign temp_floor    = {1'b0, temp_div.quot} - {1'b0, htfd_pkg::TEMP_OFFSET};
    assign temp_round_up = temp_floor[15] && (temp_div.rem != 16'd0);
    assign temp_trunc    = temp_floor + {15'd0, temp_round_up};

    // ------------------------------------------------------------------
    // Result register: drop the values to zero on a CRC mismatch
    // ------------------------------------------------------------------
    logic               frame_status_reg;
    logic signed [14:0] temp_centi_reg;
    logic [13:0]        humid_centi_reg;

    always_ff @(posedge clk)
    begin
        if (result_load && stage_valid_reg)
        begin
            frame_status_reg <= !crc_ok;
            temp_centi_reg   <= crc_ok ? signed'(temp_trunc[14:0]) : 15'sd0;
            humid_centi_reg  <= crc_ok ? humid_div.quot[13:0] : 14'd0;
        end
    end

    assign result_valid = result_valid_reg;
    assign frame_status = frame_status_reg;
    assign temp_centi   = temp_centi_reg;
    assign humid_centi  = humid_centi_reg;

endmodule

`default_nettype wire
